>>> hw/rtl/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg
// Request codes, result status codes and the command and status bundles
// shared by the deque controller and datapath.
// ----------------------------------------------------------------------------
package dqe_pkg;

   localparam int VALUE_W = 32;
   localparam int CODE_W  = 3;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 7;

   typedef enum logic [CODE_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_END   = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_END    = 3'd3,
      REQ_ERASE      = 3'd4
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic op_exec;
      logic walk_step;
      logic load_op;
      logic load_held;
   } cmd_type;

   typedef struct packed {
      logic walk_needed;
      logic walk_done;
   } stat_type;

endpackage

>>> hw/rtl/deque_with_erase_by_value_top.sv
// ----------------------------------------------------------------------------
// deque_with_erase_by_value_top
// Bounded double-ended queue of signed 32-bit values with erase of all
// entries that match a value.
// ----------------------------------------------------------------------------
// One item is taken at a time. A push or a pop is accepted, then executed and
// its result loaded into the result register while that register is free.
// An erase walks the held entries through the ring store, one entry per
// cycle. Every item gives one result; the store needs no clearing after reset.
module deque_with_erase_by_value_top #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // erased_count[6:0], size_now[13:7], zero[15:14]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   dqe_pkg::cmd_type  cmd;
   dqe_pkg::stat_type stat;
   logic [dqe_pkg::CNT_W-1:0] rsp_erased;
   logic [dqe_pkg::CNT_W-1:0] rsp_size;

   dqe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dqe_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_code   (req_tuser),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_tuser),
      .rsp_erased (rsp_erased),
      .rsp_size   (rsp_size)
   );

   assign rsp_tdata = {2'b00, rsp_size, rsp_erased};

endmodule

>>> hw/rtl/dqe_ctrl.sv
// ----------------------------------------------------------------------------
// dqe_ctrl
// Request sequencer: accepts an item, runs the operation or the erase walk,
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module dqe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  dqe_pkg::stat_type stat,
   output dqe_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_OP     = 4'b0010,
      S_WALK   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd.capture   = req_tvalid && req_tready;
      cmd.op_exec   = (state_ff == S_OP);
      cmd.walk_step = (state_ff == S_WALK);
      cmd.load_op   = (state_ff == S_OP) && !stat.walk_needed && slot_free;
      cmd.load_held = (state_ff == S_FINISH) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_OP;
         end
         S_OP: begin
            if (stat.walk_needed) state_in = S_WALK;
            else if (slot_free)   state_in = S_IDLE;
            else                  state_in = S_FINISH;
         end
         S_WALK: begin
            if (stat.walk_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_op || cmd.load_held) rsp_valid_in = 1'b1;
      else if (rsp_tready)              rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/dqe_datapath.sv
// ----------------------------------------------------------------------------
// dqe_datapath
// Ring store, front pointer and count, the erase walk with its read and
// compaction pointers, and the result registers.
// ----------------------------------------------------------------------------
module dqe_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dqe_pkg::CODE_W-1:0]    req_code,
   input  logic signed [dqe_pkg::VALUE_W-1:0] req_value,
   input  dqe_pkg::cmd_type              cmd,
   output dqe_pkg::stat_type             stat,
   output logic [dqe_pkg::STAT_W-1:0]    rsp_status,
   output logic [dqe_pkg::CNT_W-1:0]     rsp_erased,
   output logic [dqe_pkg::CNT_W-1:0]     rsp_size
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [dqe_pkg::VALUE_W-1:0] store_ff [DEPTH];
   logic signed [dqe_pkg::VALUE_W-1:0] rd_data_ff;

   logic [dqe_pkg::CODE_W-1:0]         code_ff;
   logic signed [dqe_pkg::VALUE_W-1:0] value_ff;

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rd_pos_ff, rd_pos_in;
   logic [AW-1:0] wr_pos_ff, wr_pos_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic          vld_ff, vld_in;

   dqe_pkg::status_type res_status_ff, res_status_in;
   logic [CW-1:0]       res_erased_ff, res_erased_in;
   dqe_pkg::status_type op_status;

   logic                               we;
   logic [AW-1:0]                      waddr;
   logic signed [dqe_pkg::VALUE_W-1:0] wdata;

   logic          full, empty, walk_done;
   logic [AW:0]   end_sum;
   logic [AW-1:0] end_pos;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
   endfunction

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign walk_done = (rd_idx_ff == count_ff) && !vld_ff;
   assign end_sum   = (AW + 1)'(front_ff) + (AW + 1)'(count_ff);
   assign end_pos   = (end_sum >= (AW + 1)'(DEPTH)) ? AW'(end_sum - (AW + 1)'(DEPTH))
                                                    : AW'(end_sum);

   always_comb begin
      stat.walk_needed = (code_ff == dqe_pkg::REQ_ERASE) && !empty;
      stat.walk_done   = walk_done;
   end

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      rd_pos_in     = rd_pos_ff;
      wr_pos_in     = wr_pos_ff;
      rd_idx_in     = rd_idx_ff;
      kept_in       = kept_ff;
      vld_in        = 1'b0;
      res_status_in = res_status_ff;
      res_erased_in = res_erased_ff;
      op_status     = dqe_pkg::ST_OK;
      we            = 1'b0;
      waddr         = wr_pos_ff;
      wdata         = value_ff;

      if (cmd.op_exec) begin
         unique case (code_ff)
            dqe_pkg::REQ_PUSH_FRONT: begin
               if (full) begin
                  op_status = dqe_pkg::ST_OVERFLOW;
               end else begin
                  front_in = ring_dec(front_ff);
                  count_in = count_ff + CW'(1);
                  we       = 1'b1;
                  waddr    = ring_dec(front_ff);
               end
            end
            dqe_pkg::REQ_PUSH_END: begin
               if (full) begin
                  op_status = dqe_pkg::ST_OVERFLOW;
               end else begin
                  count_in = count_ff + CW'(1);
                  we       = 1'b1;
                  waddr    = end_pos;
               end
            end
            dqe_pkg::REQ_POP_FRONT: begin
               if (empty) begin
                  op_status = dqe_pkg::ST_UNDERFLOW;
               end else begin
                  front_in = ring_inc(front_ff);
                  count_in = count_ff - CW'(1);
               end
            end
            dqe_pkg::REQ_POP_END: begin
               if (empty) op_status = dqe_pkg::ST_UNDERFLOW;
               else       count_in  = count_ff - CW'(1);
            end
            dqe_pkg::REQ_ERASE: begin
               if (empty) begin
                  op_status = dqe_pkg::ST_UNDERFLOW;
               end else begin
                  rd_pos_in = front_ff;
                  wr_pos_in = front_ff;
                  rd_idx_in = '0;
                  kept_in   = '0;
               end
            end
            default: ;
         endcase
         res_status_in = op_status;
         res_erased_in = '0;
      end

      if (cmd.walk_step) begin
         if (rd_idx_ff != count_ff) begin
            rd_pos_in = ring_inc(rd_pos_ff);
            rd_idx_in = rd_idx_ff + CW'(1);
            vld_in    = 1'b1;
         end
         // keep entries that do not match, compacted toward the front
         if (vld_ff && (rd_data_ff != value_ff)) begin
            we        = 1'b1;
            waddr     = wr_pos_ff;
            wdata     = rd_data_ff;
            wr_pos_in = ring_inc(wr_pos_ff);
            kept_in   = kept_ff + CW'(1);
         end
         if (walk_done) begin
            count_in      = kept_ff;
            res_status_in = dqe_pkg::ST_OK;
            res_erased_in = count_ff - kept_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) store_ff[waddr] <= wdata;
      rd_data_ff <= store_ff[rd_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff  <= req_code;
         value_ff <= req_value;
      end
      rd_pos_ff     <= rd_pos_in;
      wr_pos_ff     <= wr_pos_in;
      rd_idx_ff     <= rd_idx_in;
      kept_ff       <= kept_in;
      res_status_ff <= res_status_in;
      res_erased_ff <= res_erased_in;
      if (cmd.load_op) begin
         rsp_status <= op_status;
         rsp_erased <= '0;
         rsp_size   <= dqe_pkg::CNT_W'(count_in);
      end else if (cmd.load_held) begin
         rsp_status <= res_status_ff;
         rsp_erased <= dqe_pkg::CNT_W'(res_erased_ff);
         rsp_size   <= dqe_pkg::CNT_W'(count_ff);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond store depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= AW'(DEPTH - 1))
      else $error("front pointer outside the ring");

   a_kept_le_read: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (kept_ff <= rd_idx_ff) && (rd_idx_ff <= count_ff))
      else $error("erase walk compaction ahead of reads");

   a_op_step_one: assert property (@(posedge clock) disable iff (reset)
      cmd.op_exec |=> (count_ff == $past(count_ff)) ||
                      (count_ff == $past(count_ff) + CW'(1)) ||
                      (count_ff + CW'(1) == $past(count_ff)))
      else $error("push or pop changed count by more than one");

endmodule
